// ===== hw/rtl/ptv_pkg.sv =====
package ptv_pkg;

   localparam int TEMP_W  = 15;
   localparam int VOLT_W  = 14;
   localparam int FRAC_W  = 28;
   localparam int OUT_SHIFT = 16;

   localparam int TABLE_LEN  = 13;
   localparam int NUM_POINTS = 13;
   localparam int USED_POINTS = (NUM_POINTS < TABLE_LEN) ? NUM_POINTS : TABLE_LEN;
   localparam int NUM_SEG    = USED_POINTS - 1;
   localparam int TABLE_SEG  = TABLE_LEN - 1;
   localparam int SEG_W      = (NUM_SEG > 1) ? $clog2(NUM_SEG) : 1;

   localparam int BASE_W  = 29;
   localparam int SLOPE_W = 18;
   localparam int DELTA_W = 11;
   localparam int ACC_W   = 30;

   typedef logic signed [TEMP_W-1:0] temp_type;
   typedef logic [VOLT_W-1:0]        volt_type;
   typedef logic [SEG_W-1:0]         seg_type;
   typedef logic [DELTA_W-1:0]       delta_type;
   typedef logic [BASE_W-1:0]        base_type;
   typedef logic [SLOPE_W-1:0]       slope_type;
   typedef logic [ACC_W-1:0]         acc_type;

   // breakpoints in 1/16 degree
   localparam temp_type BP_TEMP [TABLE_LEN] = '{
      15'sd0,    15'sd320,  15'sd720,  15'sd992,  15'sd1600, 15'sd2208, 15'sd2816,
      15'sd3440, 15'sd4096, 15'sd4752, 15'sd5440, 15'sd6096, 15'sd8000
   };

   // segment base voltage in 2^-28 V, rounded to nearest
   localparam base_type SEG_BASE [TABLE_SEG] = '{
      BASE_W'(((64'd700  << FRAC_W) + 64'd500) / 64'd1000),
      BASE_W'(((64'd780  << FRAC_W) + 64'd500) / 64'd1000),
      BASE_W'(((64'd852  << FRAC_W) + 64'd500) / 64'd1000),
      BASE_W'(((64'd900  << FRAC_W) + 64'd500) / 64'd1000),
      BASE_W'(((64'd1000 << FRAC_W) + 64'd500) / 64'd1000),
      BASE_W'(((64'd1101 << FRAC_W) + 64'd500) / 64'd1000),
      BASE_W'(((64'd1200 << FRAC_W) + 64'd500) / 64'd1000),
      BASE_W'(((64'd1300 << FRAC_W) + 64'd500) / 64'd1000),
      BASE_W'(((64'd1400 << FRAC_W) + 64'd500) / 64'd1000),
      BASE_W'(((64'd1500 << FRAC_W) + 64'd500) / 64'd1000),
      BASE_W'(((64'd1603 << FRAC_W) + 64'd500) / 64'd1000),
      BASE_W'(((64'd1700 << FRAC_W) + 64'd500) / 64'd1000)
   };

   // segment slope in 2^-28 V per 1/16 degree, rounded to nearest
   localparam slope_type SEG_SLOPE [TABLE_SEG] = '{
      SLOPE_W'(((64'd80   << FRAC_W) + 64'd160000) / 64'd320000),
      SLOPE_W'(((64'd72   << FRAC_W) + 64'd200000) / 64'd400000),
      SLOPE_W'(((64'd48   << FRAC_W) + 64'd136000) / 64'd272000),
      SLOPE_W'(((64'd100  << FRAC_W) + 64'd304000) / 64'd608000),
      SLOPE_W'(((64'd101  << FRAC_W) + 64'd304000) / 64'd608000),
      SLOPE_W'(((64'd99   << FRAC_W) + 64'd304000) / 64'd608000),
      SLOPE_W'(((64'd100  << FRAC_W) + 64'd312000) / 64'd624000),
      SLOPE_W'(((64'd100  << FRAC_W) + 64'd328000) / 64'd656000),
      SLOPE_W'(((64'd100  << FRAC_W) + 64'd328000) / 64'd656000),
      SLOPE_W'(((64'd103  << FRAC_W) + 64'd344000) / 64'd688000),
      SLOPE_W'(((64'd97   << FRAC_W) + 64'd328000) / 64'd656000),
      SLOPE_W'(((64'd1300 << FRAC_W) + 64'd952000) / 64'd1904000)
   };

   localparam volt_type VOLT_MIN = VOLT_W'(SEG_BASE[0] >> OUT_SHIFT);
   localparam volt_type VOLT_MAX = VOLT_W'(((64'd3000 << FRAC_W) / 64'd1000) >> OUT_SHIFT);

endpackage

// ===== hw/rtl/ptv_if.sv =====
interface ptv_req_if;
   logic                valid;
   logic                ready;
   ptv_pkg::temp_type   temp_sixteenths;

   modport source (output valid, output temp_sixteenths, input ready);
   modport sink   (input valid, input temp_sixteenths, output ready);
endinterface

interface ptv_rsp_if;
   logic                valid;
   logic                ready;
   ptv_pkg::volt_type   voltage_q12;
   logic                in_range;

   modport source (output valid, output voltage_q12, output in_range, input ready);
   modport sink   (input valid, input voltage_q12, input in_range, output ready);
endinterface

// ===== hw/rtl/piecewise_linear_temp_to_volt_unit.sv =====
// throughput: one item per cycle while no result waits on rsp ready; an item
// accepted from req reaches the rsp channel along the path input register,
// segment compare, one 18x11 multiply-add, result register
// a result waiting on rsp ready stalls the result stage and a full input stage
// reset (synchronous, active high) empties both stages; no table state to clear
module piecewise_linear_temp_to_volt_unit (
   input  logic          clock,
   input  logic          reset,
   ptv_req_if.sink       req_if,
   ptv_rsp_if.source     rsp_if
);

   logic                 advance;
   logic                 s1_valid_ff, s1_valid_in;
   ptv_pkg::temp_type    s1_temp_ff, s1_temp_in;
   logic                 out_valid_ff, out_valid_in;
   ptv_pkg::volt_type    out_volt_ff, out_volt_in;
   logic                 out_hit_ff, out_hit_in;

   ptv_pkg::seg_type     seg;
   logic                 hit;
   logic signed [ptv_pkg::TEMP_W:0] diff;
   ptv_pkg::delta_type   delta;
   ptv_pkg::acc_type     acc;

   assign advance       = !out_valid_ff || rsp_if.ready;
   assign req_if.ready  = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_temp_in  = s1_temp_ff;
      if (req_if.ready) begin
         s1_valid_in = req_if.valid;
         s1_temp_in  = req_if.temp_sixteenths;
      end
   end

   // segment search over ascending breakpoints
   always_comb begin
      hit = (s1_temp_ff >= ptv_pkg::BP_TEMP[0])
         && (s1_temp_ff < ptv_pkg::BP_TEMP[ptv_pkg::NUM_SEG]);
      seg = '0;
      for (int i = 1; i < ptv_pkg::NUM_SEG; i++) begin
         if (s1_temp_ff >= ptv_pkg::BP_TEMP[i]) begin
            seg = ptv_pkg::SEG_W'(i);
         end
      end
      diff  = (ptv_pkg::TEMP_W+1)'(s1_temp_ff) - (ptv_pkg::TEMP_W+1)'(ptv_pkg::BP_TEMP[seg]);
      delta = diff[ptv_pkg::DELTA_W-1:0];
      acc   = ptv_pkg::ACC_W'(ptv_pkg::SEG_BASE[seg])
            + ptv_pkg::ACC_W'(ptv_pkg::SEG_SLOPE[seg]) * ptv_pkg::ACC_W'(delta);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_volt_in  = out_volt_ff;
      out_hit_in   = out_hit_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         out_hit_in   = hit;
         out_volt_in  = hit ? acc[ptv_pkg::ACC_W-1:ptv_pkg::OUT_SHIFT] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_temp_ff  <= s1_temp_in;
      out_volt_ff <= out_volt_in;
      out_hit_ff  <= out_hit_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.voltage_q12 = out_volt_ff;
   assign rsp_if.in_range    = out_hit_ff;

   a_out_of_range_zero : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_hit_ff |-> out_volt_ff == '0)
      else $error("out of range item with nonzero voltage");

   a_volt_bounds : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_hit_ff |->
         out_volt_ff >= ptv_pkg::VOLT_MIN && out_volt_ff <= ptv_pkg::VOLT_MAX)
      else $error("voltage outside table span");

   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_temp_ff))
      else $error("input stage lost an item while stalled");

   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> s1_valid_ff)
      else $error("accepted item did not enter input stage");

endmodule
